// ===== rtl/core/obfuscated_header_key_match_core_assert.svh =====
// Assertion macros used by the header key match back end.
`ifndef OBFUSCATED_HEADER_KEY_MATCH_CORE_ASSERT_SVH
`define OBFUSCATED_HEADER_KEY_MATCH_CORE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define OHKM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ohkm assertion failed");
// next-cycle implication
`define OHKM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ohkm assertion failed");
`else
`define OHKM_ASSERT_NOW(lbl, ante, cons)
`define OHKM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/ohkm_pkg.sv =====
// Types, codes and constant tables of the header key match core.
`default_nettype none
package ohkm_pkg;

    localparam int HDR_BITS = 512;

    localparam logic [2:0] CFG_SECRET_COUNT  = 3'd0;
    localparam logic [2:0] CFG_PAD_TAG_ONLY  = 3'd1;
    localparam logic [2:0] CFG_SECRET_A_LOW  = 3'd2;
    localparam logic [2:0] CFG_SECRET_A_HIGH = 3'd3;
    localparam logic [2:0] CFG_SECRET_B_LOW  = 3'd4;
    localparam logic [2:0] CFG_SECRET_B_HIGH = 3'd5;

    localparam logic [31:0] TAG_PADDED  = 32'hDDDDDDDD;
    localparam logic [31:0] TAG_MEDIUM  = 32'hEEEEEEEE;
    localparam logic [31:0] TAG_COMPACT = 32'hEFEFEFEF;

    localparam logic [1:0] KIND_PADDED  = 2'd0;
    localparam logic [1:0] KIND_MEDIUM  = 2'd1;
    localparam logic [1:0] KIND_COMPACT = 2'd2;

    localparam logic [3:0] KEY_WORD_FINAL = 4'd11;

    typedef struct packed {
        logic [1:0]   secret_count;
        logic         pad_tag_only;
        logic [127:0] secret_a;     // byte i in bits 8i+7:8i
        logic [127:0] secret_b;
    } ohkm_cfg_t;

    localparam logic [31:0] SHA_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

endpackage
`default_nettype wire

// ===== rtl/core/ohkm_ifs.sv =====
// Channel interfaces: header words in, results out, configuration writes.
`default_nettype none
interface ohkm_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] header_word;
    logic        word_last;
    modport source (output valid, header_word, word_last, input ready);
    modport sink (input valid, header_word, word_last, output ready);
endinterface

interface ohkm_out_if;
    logic               valid;
    logic               ready;
    logic               matched;
    logic [1:0]         tag_kind;
    logic signed [15:0] dc_number;
    logic               secret_index;
    logic [3:0]         key_word_index;
    logic [63:0]        key_word;
    logic               result_last;
    modport source (output valid, matched, tag_kind, dc_number, secret_index,
                    key_word_index, key_word, result_last, input ready);
    modport sink (input valid, matched, tag_kind, dc_number, secret_index,
                  key_word_index, key_word, result_last, output ready);
endinterface

interface ohkm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ohkm_front.sv =====
// Front end: collects header words and queues whole headers for the back end.
`default_nettype none
module ohkm_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    ohkm_in_if.sink                       header,
    output logic                          hdr_valid,
    input  wire logic                     hdr_ready,
    output logic [ohkm_pkg::HDR_BITS-1:0] hdr_data
);
    import ohkm_pkg::*;

    logic [63:0]         store_reg [8];
    logic [2:0]          wc_reg;
    logic [HDR_BITS-1:0] q_reg [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          cnt_reg;
    logic                take;
    logic                push;
    logic                pop;
    logic [HDR_BITS-1:0] snap;

    assign header.ready = (cnt_reg != 2'd2);
    assign take = header.valid && header.ready;
    assign push = take && header.word_last;
    assign pop  = hdr_valid && hdr_ready;
    assign hdr_valid = (cnt_reg != 2'd0);
    assign hdr_data  = q_reg[rd_ptr_reg];

    // header as it stands once the incoming last word lands in its slot
    always_comb
    begin
        for (int w = 0; w < 8; w++)
        begin
            snap[64*w +: 64] = (wc_reg == 3'(w)) ? header.header_word : store_reg[w];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg     <= 3'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (take)
            begin
                wc_reg <= header.word_last ? 3'd0 : wc_reg + 3'd1;
            end
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            store_reg[wc_reg] <= header.header_word;
        end
        if (push)
        begin
            q_reg[wr_ptr_reg] <= snap;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/ohkm_sha.sv =====
// SHA-256 of one 48-byte message, one round per cycle.
`default_nettype none
module ohkm_sha (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [383:0] msg,      // byte 0 in bits 383:376
    output logic              done,
    output logic [255:0]      digest    // byte 0 in bits 255:248
);
    import ohkm_pkg::*;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [255:0] dig_reg;
    logic [31:0] nv [8];
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] wnew;

    assign done   = done_reg;
    assign digest = dig_reg;

    always_comb
    begin
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
             + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + SHA_K[cnt_reg] + w_reg[0];
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
             + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        nv[0] = t1 + t2;
        nv[1] = v_reg[0];
        nv[2] = v_reg[1];
        nv[3] = v_reg[2];
        nv[4] = v_reg[3] + t1;
        nv[5] = v_reg[4];
        nv[6] = v_reg[5];
        nv[7] = v_reg[6];
        wnew = w_reg[0] + (rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3))
               + w_reg[9] + (rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= SHA_INIT[i];
            end
            for (int i = 0; i < 12; i++)
            begin
                w_reg[i] <= msg[383 - 32*i -: 32];
            end
            // fixed padding of a 384-bit message
            w_reg[12] <= 32'h80000000;
            w_reg[13] <= 32'h0;
            w_reg[14] <= 32'h0;
            w_reg[15] <= 32'h00000180;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= nv[i];
            end
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= wnew;
            if (cnt_reg == 6'd63)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    dig_reg[255 - 32*i -: 32] <= SHA_INIT[i] + nv[i];
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/ohkm_aes.sv =====
// AES-256 block encryption, one round per cycle, key schedule on the fly.
`default_nettype none
module ohkm_aes (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [255:0] key,      // byte 0 in bits 255:248
    input  wire logic [127:0] blk,      // byte 0 in bits 127:120
    output logic              done,
    output logic [127:0]      result    // byte 0 in bits 127:120
);
    import ohkm_pkg::*;

    function automatic logic [7:0] xt(input logic [7:0] x);
        xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    logic [7:0] s_reg [16];
    logic [7:0] ka_reg [16];
    logic [7:0] kb_reg [16];
    logic [3:0] rnd_reg;
    logic       busy_reg;
    logic       done_reg;
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] nk [16];
    logic [7:0] g [4];
    logic [3:0] nxt;
    logic [7:0] rcon;

    assign done = done_reg;
    assign nxt  = rnd_reg + 4'd1;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                t[i + 4*c] = SBOX[s_reg[i + 4*((c + i) % 4)]];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            if (rnd_reg != 4'd14)
            begin
                m[4*c]   = xt(t[4*c]) ^ xt(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
                m[4*c+1] = t[4*c] ^ xt(t[4*c+1]) ^ xt(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
                m[4*c+2] = t[4*c] ^ t[4*c+1] ^ xt(t[4*c+2]) ^ xt(t[4*c+3]) ^ t[4*c+3];
                m[4*c+3] = xt(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xt(t[4*c+3]);
            end
            else
            begin
                m[4*c]   = t[4*c];
                m[4*c+1] = t[4*c+1];
                m[4*c+2] = t[4*c+2];
                m[4*c+3] = t[4*c+3];
            end
        end
        // next round key block from the previous two
        rcon = 8'h01 << (nxt[3:1] - 3'd1);
        if (!nxt[0])
        begin
            g[0] = SBOX[kb_reg[13]] ^ rcon;
            g[1] = SBOX[kb_reg[14]];
            g[2] = SBOX[kb_reg[15]];
            g[3] = SBOX[kb_reg[12]];
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                g[i] = SBOX[kb_reg[12 + i]];
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            nk[i] = ka_reg[i] ^ g[i];
        end
        for (int i = 4; i < 16; i++)
        begin
            nk[i] = ka_reg[i] ^ nk[i - 4];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            result[127 - 8*i -: 8] = s_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= 4'd1;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= 4'd1;
            end
            else if (busy_reg)
            begin
                rnd_reg <= nxt;
                if (rnd_reg == 4'd14)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int i = 0; i < 16; i++)
            begin
                s_reg[i]  <= blk[127 - 8*i -: 8] ^ key[255 - 8*i -: 8];
                ka_reg[i] <= key[255 - 8*i -: 8];
                kb_reg[i] <= key[127 - 8*i -: 8];
            end
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 16; i++)
            begin
                s_reg[i]  <= m[i] ^ kb_reg[i];
                ka_reg[i] <= kb_reg[i];
                kb_reg[i] <= nk[i];
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/ohkm_back.sv =====
// Back end: runs the key derivation passes on a queued header and emits results.
`default_nettype none
`include "obfuscated_header_key_match_core_assert.svh"
module ohkm_back #(
    parameter int MAX_SECRETS = 2
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ohkm_pkg::ohkm_cfg_t           cfg,
    input  wire logic                          hdr_valid,
    output logic                               hdr_ready,
    input  wire logic [ohkm_pkg::HDR_BITS-1:0] hdr_data,
    ohkm_out_if.source                         result
);
    import ohkm_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PASS  = 7'b0000010,
        ST_SHA1  = 7'b0000100,
        ST_SHA2  = 7'b0001000,
        ST_AESGO = 7'b0010000,
        ST_AES   = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } bk_state_t;

    bk_state_t           state_reg;
    logic [HDR_BITS-1:0] hdr_reg;
    logic                sid_reg;
    logic                hit_reg;
    logic [1:0]          kind_reg;
    logic [15:0]         dc_reg;
    logic [3:0]          idx_reg;
    logic [255:0]        rkey_reg;
    logic [255:0]        wkey_reg;
    logic                out_valid_reg;
    logic                o_matched_reg;
    logic [1:0]          o_kind_reg;
    logic [15:0]         o_dc_reg;
    logic                o_sidx_reg;
    logic [3:0]          o_idx_reg;
    logic [63:0]         o_word_reg;
    logic                o_last_reg;

    logic [1:0]   nsec;
    logic         last_pass;
    logic [127:0] sec;
    logic [127:0] sec_be;
    logic [255:0] fwd;
    logic [255:0] rev;
    logic [127:0] ctr;
    logic         sha_start;
    logic [383:0] sha_msg;
    logic         sha_done;
    logic [255:0] sha_dig;
    logic         aes_start;
    logic         aes_done;
    logic [127:0] ks;
    logic [31:0]  tag;
    logic         ok;
    logic [1:0]   kind;
    logic [7:0]   keys [96];
    logic [63:0]  kw;
    logic         can_load;
    logic         emit_last;
    logic         emit_done;
    logic         hdr_pop;

    function automatic logic [7:0] hb(input logic [HDR_BITS-1:0] h, input int n);
        hb = h[8*n +: 8];
    endfunction

    assign nsec = (cfg.secret_count > 2'(MAX_SECRETS)) ? 2'(MAX_SECRETS) : cfg.secret_count;
    assign last_pass = (nsec == 2'd0) || (({1'b0, sid_reg} + 2'd1) >= nsec);
    assign sec = sid_reg ? cfg.secret_b : cfg.secret_a;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            sec_be[127 - 8*i -: 8] = sec[8*i +: 8];
            ctr[127 - 8*i -: 8]    = hb(hdr_reg, 40 + i);
        end
        for (int i = 0; i < 32; i++)
        begin
            fwd[255 - 8*i -: 8] = hb(hdr_reg, 8 + i);
            rev[255 - 8*i -: 8] = hb(hdr_reg, 55 - i);
        end
    end

    assign sha_start = ((state_reg == ST_PASS) && (nsec != 2'd0))
                       || ((state_reg == ST_SHA1) && sha_done);
    assign sha_msg   = (state_reg == ST_SHA1) ? {rev, sec_be} : {fwd, sec_be};
    assign aes_start = (state_reg == ST_AESGO);

    ohkm_sha u_sha (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sha_start),
        .msg    (sha_msg),
        .done   (sha_done),
        .digest (sha_dig)
    );

    // counter block for header bytes 48..63 is the IV plus three
    ohkm_aes u_aes (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (aes_start),
        .key    (rkey_reg),
        .blk    (ctr + 128'd3),
        .done   (aes_done),
        .result (ks)
    );

    always_comb
    begin
        tag = {hb(hdr_reg, 59) ^ ks[127 - 88 -: 8], hb(hdr_reg, 58) ^ ks[127 - 80 -: 8],
               hb(hdr_reg, 57) ^ ks[127 - 72 -: 8], hb(hdr_reg, 56) ^ ks[127 - 64 -: 8]};
        ok   = 1'b0;
        kind = KIND_PADDED;
        if (tag == TAG_PADDED)
        begin
            ok = 1'b1;
        end
        else if ((tag == TAG_MEDIUM) && !cfg.pad_tag_only)
        begin
            ok   = 1'b1;
            kind = KIND_MEDIUM;
        end
        else if ((tag == TAG_COMPACT) && !cfg.pad_tag_only)
        begin
            ok   = 1'b1;
            kind = KIND_COMPACT;
        end
    end

    // key store view: read key, read iv, write key, write iv
    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            keys[i]      = rkey_reg[255 - 8*i -: 8];
            keys[48 + i] = wkey_reg[255 - 8*i -: 8];
        end
        for (int i = 0; i < 16; i++)
        begin
            keys[32 + i] = hb(hdr_reg, 40 + i);
            keys[80 + i] = hb(hdr_reg, 23 - i);
        end
        for (int j = 0; j < 8; j++)
        begin
            kw[8*j +: 8] = keys[{idx_reg, 3'b000} + 7'(j)];
        end
    end

    assign can_load  = !out_valid_reg || result.ready;
    assign emit_last = !hit_reg || (idx_reg == KEY_WORD_FINAL);
    assign emit_done = (state_reg == ST_EMIT) && can_load && emit_last;
    assign hdr_ready = (state_reg == ST_IDLE);
    assign hdr_pop   = hdr_valid && hdr_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            sid_reg       <= 1'b0;
            idx_reg       <= 4'd0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_EMIT) && can_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (hdr_pop)
                    begin
                        sid_reg   <= 1'b0;
                        state_reg <= ST_PASS;
                    end
                end
                ST_PASS:
                begin
                    state_reg <= (nsec != 2'd0) ? ST_SHA1 : ST_AESGO;
                end
                ST_SHA1:
                begin
                    if (sha_done)
                    begin
                        state_reg <= ST_SHA2;
                    end
                end
                ST_SHA2:
                begin
                    if (sha_done)
                    begin
                        state_reg <= ST_AESGO;
                    end
                end
                ST_AESGO:
                begin
                    state_reg <= ST_AES;
                end
                ST_AES:
                begin
                    if (aes_done)
                    begin
                        idx_reg <= 4'd0;
                        if (ok)
                        begin
                            hit_reg   <= 1'b1;
                            state_reg <= ST_EMIT;
                        end
                        else if (last_pass)
                        begin
                            hit_reg   <= 1'b0;
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            sid_reg   <= ~sid_reg;
                            state_reg <= ST_PASS;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (can_load)
                    begin
                        idx_reg <= idx_reg + 4'd1;
                        if (emit_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_pop)
        begin
            hdr_reg <= hdr_data;
        end
        if ((state_reg == ST_PASS) && (nsec == 2'd0))
        begin
            rkey_reg <= fwd;
            wkey_reg <= rev;
        end
        if ((state_reg == ST_SHA1) && sha_done)
        begin
            rkey_reg <= sha_dig;
        end
        if ((state_reg == ST_SHA2) && sha_done)
        begin
            wkey_reg <= sha_dig;
        end
        if ((state_reg == ST_AES) && aes_done)
        begin
            kind_reg <= kind;
            dc_reg   <= {hb(hdr_reg, 61) ^ ks[127 - 104 -: 8],
                         hb(hdr_reg, 60) ^ ks[127 - 96 -: 8]};
        end
        if ((state_reg == ST_EMIT) && can_load)
        begin
            o_matched_reg <= hit_reg;
            o_kind_reg    <= hit_reg ? kind_reg : KIND_PADDED;
            o_dc_reg      <= hit_reg ? dc_reg : 16'd0;
            o_sidx_reg    <= hit_reg && sid_reg;
            o_idx_reg     <= hit_reg ? idx_reg : 4'd0;
            o_word_reg    <= hit_reg ? kw : 64'd0;
            o_last_reg    <= emit_last;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.matched        = o_matched_reg;
    assign result.tag_kind       = o_kind_reg;
    assign result.dc_number      = o_dc_reg;
    assign result.secret_index   = o_sidx_reg;
    assign result.key_word_index = o_idx_reg;
    assign result.key_word       = o_word_reg;
    assign result.result_last    = o_last_reg;

    `OHKM_ASSERT_NOW(a_sha_start_state, sha_start, (state_reg == ST_PASS) || (state_reg == ST_SHA1))
    `OHKM_ASSERT_NOW(a_pop_idle, hdr_pop, state_reg == ST_IDLE)
    `OHKM_ASSERT_NEXT(a_emit_to_idle, emit_done, state_reg == ST_IDLE)
    `OHKM_ASSERT_NEXT(a_aes_start_once, aes_start, !aes_start)
endmodule
`default_nettype wire

// ===== rtl/core/obfuscated_header_key_match_core.sv =====
// Top level of the obfuscated header key match core.
// Header words enter one per cycle into a collector while the queue has room; each completed
// 64-byte header is queued (two deep) for the back end, which tries each configured secret in
// turn. A keyed pass runs two SHA-256 compressions at one round a cycle, then 14 AES-256 rounds
// at one round a cycle; an unkeyed pass runs only the AES rounds. The back end then emits one
// result word per cycle while the result side takes them (12 on a match, 1 otherwise).
// Configuration writes are always accepted and are registered before the back end uses them.
`default_nettype none
module obfuscated_header_key_match_core #(
    parameter int MAX_SECRETS = 2
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ohkm_in_if.sink    header,
    ohkm_out_if.source result,
    ohkm_cfg_if.sink   cfg
);
    import ohkm_pkg::*;

    ohkm_cfg_t           cfg_reg;
    logic                hdr_valid;
    logic                hdr_ready;
    logic [HDR_BITS-1:0] hdr_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_SECRET_COUNT:  cfg_reg.secret_count     <= cfg.data[1:0];
                CFG_PAD_TAG_ONLY:  cfg_reg.pad_tag_only     <= cfg.data[0];
                CFG_SECRET_A_LOW:  cfg_reg.secret_a[63:0]   <= cfg.data;
                CFG_SECRET_A_HIGH: cfg_reg.secret_a[127:64] <= cfg.data;
                CFG_SECRET_B_LOW:  cfg_reg.secret_b[63:0]   <= cfg.data;
                CFG_SECRET_B_HIGH: cfg_reg.secret_b[127:64] <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    ohkm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .header    (header),
        .hdr_valid (hdr_valid),
        .hdr_ready (hdr_ready),
        .hdr_data  (hdr_data)
    );

    ohkm_back #(
        .MAX_SECRETS (MAX_SECRETS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .hdr_valid (hdr_valid),
        .hdr_ready (hdr_ready),
        .hdr_data  (hdr_data),
        .result    (result)
    );
endmodule
`default_nettype wire

// ===== sim/obfuscated_header_key_match_core_tb.sv =====
// Self-checking testbench of the header key match core: crafted and random headers vs a predictor.
`timescale 1ns / 100ps
`default_nettype none

typedef struct packed {
    bit        matched;
    bit [1:0]  tag_kind;
    bit [15:0] dc_number;
    bit        secret_index;
    bit [3:0]  key_word_index;
    bit [63:0] key_word;
    bit        result_last;
} key_result_t;

class key_match_scoreboard;
    bit [1:0]    secret_count;
    bit          pad_tag_only;
    bit [63:0]   sec_a_lo, sec_a_hi, sec_b_lo, sec_b_hi;
    bit [63:0]   hdr_slots[8];
    bit [2:0]    word_cnt;
    key_result_t key_results_q[$];
    int          errors;

    function int secrets_used();
        return (secret_count > 2) ? 2 : int'(secret_count);
    endfunction

    function void write_reg(bit [2:0] idx, bit [63:0] val);
        case (idx)
            ohkm_pkg::CFG_SECRET_COUNT:  secret_count = val[1:0];
            ohkm_pkg::CFG_PAD_TAG_ONLY:  pad_tag_only = val[0];
            ohkm_pkg::CFG_SECRET_A_LOW:  sec_a_lo = val;
            ohkm_pkg::CFG_SECRET_A_HIGH: sec_a_hi = val;
            ohkm_pkg::CFG_SECRET_B_LOW:  sec_b_lo = val;
            ohkm_pkg::CFG_SECRET_B_HIGH: sec_b_hi = val;
            default: ;
        endcase
    endfunction

    function bit [31:0] rotr(bit [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // single-block digest of a 48-byte message
    function void sha256_48(input bit [7:0] msg[48], output bit [7:0] dig[32]);
        bit [7:0]  blk[64];
        bit [31:0] w[64];
        bit [31:0] h[8];
        bit [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
        for (int i = 0; i < 64; i++) blk[i] = (i < 48) ? msg[i] : 8'h00;
        blk[48] = 8'h80; blk[62] = 8'h01; blk[63] = 8'h80;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++) h[i] = ohkm_pkg::SHA_INIT[i];
        a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4]; f = h[5]; g = h[6]; hh = h[7];
        for (int i = 0; i < 64; i++) begin
            t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + ohkm_pkg::SHA_K[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            hh = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        h[0] += a; h[1] += b; h[2] += c; h[3] += d;
        h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
        for (int i = 0; i < 8; i++) begin
            dig[4*i]   = h[i][31:24];
            dig[4*i+1] = h[i][23:16];
            dig[4*i+2] = h[i][15:8];
            dig[4*i+3] = h[i][7:0];
        end
    endfunction

    function bit [7:0] xt(bit [7:0] x);
        return (x << 1) ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function void aes256_encrypt(input bit [7:0] key[32], input bit [7:0] din[16],
                                 output bit [7:0] dout[16]);
        bit [7:0] rk[240];
        bit [7:0] s[16];
        bit [7:0] t[16];
        bit [7:0] tmp[4];
        bit [7:0] rcon, x, a0, a1, a2, a3;
        rcon = 8'h01;
        for (int i = 0; i < 32; i++) rk[i] = key[i];
        for (int i = 8; i < 60; i++) begin
            for (int c = 0; c < 4; c++) tmp[c] = rk[4*(i-1) + c];
            if ((i & 7) == 0) begin
                x = tmp[0];
                tmp[0] = ohkm_pkg::SBOX[tmp[1]] ^ rcon;
                tmp[1] = ohkm_pkg::SBOX[tmp[2]];
                tmp[2] = ohkm_pkg::SBOX[tmp[3]];
                tmp[3] = ohkm_pkg::SBOX[x];
                rcon = xt(rcon);
            end else if ((i & 7) == 4) begin
                for (int c = 0; c < 4; c++) tmp[c] = ohkm_pkg::SBOX[tmp[c]];
            end
            for (int c = 0; c < 4; c++) rk[4*i + c] = rk[4*(i-8) + c] ^ tmp[c];
        end
        for (int i = 0; i < 16; i++) s[i] = din[i] ^ rk[i];
        for (int r = 1; r <= 14; r++) begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[i + 4*c] = ohkm_pkg::SBOX[s[i + 4*((c + i) & 3)]];
            if (r < 14) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    t[4*c]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
                    t[4*c+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
                    t[4*c+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
                    t[4*c+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
                end
            end
            for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*r + i];
        end
        for (int i = 0; i < 16; i++) dout[i] = s[i];
    endfunction

    // key material (rkey, riv, wkey, wiv) and keystream block 3 for one pass
    function void derive_pass(input bit [7:0] hb[64], input int sid,
                              output bit [7:0] keys[96], output bit [7:0] ks[16]);
        bit [7:0]   sec[16];
        bit [7:0]   msg[48];
        bit [7:0]   dig[32];
        bit [7:0]   rkey[32];
        bit [7:0]   ctr[16];
        bit [63:0]   lo, hi;
        bit [127:0] cval;
        lo = sid ? sec_b_lo : sec_a_lo;
        hi = sid ? sec_b_hi : sec_a_hi;
        for (int i = 0; i < 8; i++) begin
            sec[i] = lo[8*i +: 8];
            sec[8+i] = hi[8*i +: 8];
        end
        for (int i = 0; i < 32; i++) keys[48+i] = hb[55-i];
        for (int i = 0; i < 16; i++) keys[80+i] = hb[23-i];
        for (int i = 0; i < 16; i++) keys[32+i] = hb[40+i];
        if (secrets_used() != 0) begin
            for (int i = 0; i < 32; i++) msg[i] = hb[8+i];
            for (int i = 0; i < 16; i++) msg[32+i] = sec[i];
            sha256_48(msg, dig);
            for (int i = 0; i < 32; i++) keys[i] = dig[i];
            for (int i = 0; i < 32; i++) msg[i] = keys[48+i];
            sha256_48(msg, dig);
            for (int i = 0; i < 32; i++) keys[48+i] = dig[i];
        end else begin
            for (int i = 0; i < 32; i++) keys[i] = hb[8+i];
        end
        for (int i = 0; i < 16; i++) cval[127 - 8*i -: 8] = keys[32+i];
        cval = cval + 128'd3;
        for (int i = 0; i < 16; i++) ctr[i] = cval[127 - 8*i -: 8];
        for (int i = 0; i < 32; i++) rkey[i] = keys[i];
        aes256_encrypt(rkey, ctr, ks);
    endfunction

    function void note_word(bit [63:0] w, bit last);
        bit [7:0]    hb[64];
        bit [7:0]    keys[96];
        bit [7:0]    ks[16];
        bit [31:0]   tag;
        bit [15:0]   dc;
        bit [1:0]    kind;
        bit          ok;
        int          passes;
        key_result_t r;
        hdr_slots[word_cnt] = w;
        word_cnt++;
        if (!last) return;
        word_cnt = 0;
        for (int i = 0; i < 64; i++) hb[i] = hdr_slots[i/8][8*(i%8) +: 8];
        passes = (secrets_used() == 0) ? 1 : secrets_used();
        for (int sid = 0; sid < passes; sid++) begin
            derive_pass(hb, sid, keys, ks);
            for (int j = 0; j < 4; j++) tag[8*j +: 8] = hb[56+j] ^ ks[8+j];
            ok = 1'b0;
            kind = ohkm_pkg::KIND_PADDED;
            if (tag == ohkm_pkg::TAG_PADDED) ok = 1'b1;
            else if (tag == ohkm_pkg::TAG_MEDIUM && !pad_tag_only) begin
                ok = 1'b1; kind = ohkm_pkg::KIND_MEDIUM;
            end else if (tag == ohkm_pkg::TAG_COMPACT && !pad_tag_only) begin
                ok = 1'b1; kind = ohkm_pkg::KIND_COMPACT;
            end
            if (ok) begin
                dc = {hb[61] ^ ks[13], hb[60] ^ ks[12]};
                for (int k = 0; k < 12; k++) begin
                    r.matched = 1'b1;
                    r.tag_kind = kind;
                    r.dc_number = dc;
                    r.secret_index = (secrets_used() != 0) ? sid[0] : 1'b0;
                    r.key_word_index = k[3:0];
                    for (int j = 0; j < 8; j++) r.key_word[8*j +: 8] = keys[8*k + j];
                    r.result_last = (k[3:0] == ohkm_pkg::KEY_WORD_FINAL);
                    key_results_q.push_back(r);
                end
                return;
            end
        end
        r = '0;
        r.result_last = 1'b1;
        key_results_q.push_back(r);
    endfunction

    task report(string msg);
        errors++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_result(key_result_t got);
        key_result_t e;
        if (key_results_q.size() == 0) begin
            report($sformatf("unexpected result %p", got));
            return;
        end
        e = key_results_q.pop_front();
        if (got.matched !== e.matched)
            report($sformatf("matched %0d exp %0d", got.matched, e.matched));
        if (got.tag_kind !== e.tag_kind)
            report($sformatf("tag_kind %0d exp %0d", got.tag_kind, e.tag_kind));
        if (got.dc_number !== e.dc_number)
            report($sformatf("dc_number %h exp %h", got.dc_number, e.dc_number));
        if (got.secret_index !== e.secret_index)
            report($sformatf("secret_index %0d exp %0d", got.secret_index, e.secret_index));
        if (got.key_word_index !== e.key_word_index)
            report($sformatf("key_word_index %0d exp %0d", got.key_word_index,
                             e.key_word_index));
        if (got.key_word !== e.key_word)
            report($sformatf("key_word[%0d] %h exp %h", e.key_word_index, got.key_word,
                             e.key_word));
        if (got.result_last !== e.result_last)
            report($sformatf("result_last %0d exp %0d", got.result_last, e.result_last));
    endtask
endclass

module obfuscated_header_key_match_core_tb;
    import ohkm_pkg::*;

    logic clk;
    logic rst_n;
    bit   calm;
    key_match_scoreboard sb;

    ohkm_in_if  hdr_ch ();
    ohkm_out_if res_ch ();
    ohkm_cfg_if cfg_ch ();

    obfuscated_header_key_match_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .header (hdr_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_result('{res_ch.matched, res_ch.tag_kind, res_ch.dc_number,
                              res_ch.secret_index, res_ch.key_word_index,
                              res_ch.key_word, res_ch.result_last});
    end

    // result side back-pressure
    initial begin
        int n;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            n = calm ? 0 : $urandom_range(0, 6);
            if (n > 0) begin
                @(negedge clk) res_ch.ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk) res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
        end
    end

    initial begin
        #4000000;
        $display("obfuscated_header_key_match_core_tb: done, errors");
        $finish;
    end

    task automatic write_reg(bit [2:0] idx, bit [63:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.write_reg(idx, val);
        @(negedge clk) cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_word(bit [63:0] w, bit last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        @(negedge clk);
        if (gap > 0) begin
            hdr_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        hdr_ch.valid       <= 1'b1;
        hdr_ch.header_word <= w;
        hdr_ch.word_last   <= last;
        do @(posedge clk); while (!hdr_ch.ready);
        sb.note_word(w, last);
    endtask

    // wait for every expected result, then let the back end settle
    task automatic drain();
        @(negedge clk) hdr_ch.valid <= 1'b0;
        while (sb.key_results_q.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    // kind < 0 leaves the tag bytes as filled; fill: 0 random, 1 zeros, 2 ones
    task automatic make_header(output bit [63:0] w[8], input int kind, input int sid,
                               input bit set_dc, input bit [15:0] dc, input int fill);
        bit [7:0]  hb[64];
        bit [7:0]  keys[96];
        bit [7:0]  ks[16];
        bit [31:0] tagv;
        for (int i = 0; i < 64; i++)
            hb[i] = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hff : 8'($urandom);
        if (kind >= 0) begin
            sb.derive_pass(hb, sid, keys, ks);
            tagv = (kind == 0) ? TAG_PADDED : (kind == 1) ? TAG_MEDIUM : TAG_COMPACT;
            for (int j = 0; j < 4; j++) hb[56+j] = tagv[8*j +: 8] ^ ks[8+j];
            if (set_dc) begin
                hb[60] = dc[7:0] ^ ks[12];
                hb[61] = dc[15:8] ^ ks[13];
            end
        end
        for (int i = 0; i < 64; i++) w[i/8][8*(i%8) +: 8] = hb[i];
    endtask

    task automatic send_header(bit [63:0] w[8]);
        for (int i = 0; i < 8; i++) send_word(w[i], i == 7);
    endtask

    task automatic random_header();
        bit [63:0] w[8];
        int mode, passes, n, fill;
        mode   = $urandom_range(0, 9);
        passes = (sb.secrets_used() == 0) ? 1 : sb.secrets_used();
        fill   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
        if (mode <= 6) begin
            make_header(w, $urandom_range(0, 2), $urandom_range(0, passes - 1),
                        1'b0, 16'h0000, fill);
            send_header(w);
        end else if (mode == 7) begin
            make_header(w, -1, 0, 1'b0, 16'h0000, fill);
            send_header(w);
        end else begin
            // early last flag, or a run past eight words that wraps the slot counter
            n = (mode == 8) ? $urandom_range(1, 7) : $urandom_range(9, 11);
            for (int i = 0; i < n; i++) send_word({$urandom, $urandom}, i == n - 1);
        end
    endtask

    initial begin
        bit [63:0] w[8];
        bit [63:0] regs[6];
        sb = new;
        calm = 1'b0;
        hdr_ch.valid = 1'b0;
        hdr_ch.header_word = '0;
        hdr_ch.word_last = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_SECRET_COUNT;
        cfg_ch.data = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // directed: unkeyed pass, each tag kind, field extremes
        make_header(w, 0, 0, 1'b1, 16'h0000, 1);
        send_header(w);
        make_header(w, 1, 0, 1'b1, 16'h8000, 2);
        send_header(w);
        make_header(w, 2, 0, 1'b1, 16'h7fff, 0);
        send_header(w);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: regs = '{64'd0, 64'd1, 64'd0, 64'd0, 64'd0, 64'd0};
                1: regs = '{64'd1, 64'd0, {$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom}};
                2: regs = '{64'd2, 64'd0, '1, '1, {$urandom, $urandom},
                            {$urandom, $urandom}};
                3: regs = '{64'd3, 64'd1, {$urandom, $urandom}, {$urandom, $urandom},
                            '1, '1};
                4: regs = '{64'd2, 64'd1, 64'd0, 64'd0, 64'd0, 64'd0};
                default: regs = '{64'd1, 64'd0, {$urandom, $urandom},
                                  {$urandom, $urandom}, '1, 64'd0};
            endcase
            for (int i = 0; i < 6; i++) write_reg(i[2:0], regs[i]);
            calm = (ph == 2);
            for (int h = 0; h < 8; h++) begin
                if (ph == 3 && h == 4) drain();
                random_header();
            end
        end

        @(negedge clk) hdr_ch.valid <= 1'b0;
        while (sb.key_results_q.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (sb.errors == 0)
            $display("obfuscated_header_key_match_core_tb: done, clean");
        else
            $display("obfuscated_header_key_match_core_tb: done, errors");
        $finish;
    end
endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ohkm_pkg.sv
rtl/core/ohkm_ifs.sv
rtl/core/ohkm_front.sv
rtl/core/ohkm_sha.sv
rtl/core/ohkm_aes.sv
rtl/core/ohkm_back.sv
rtl/core/obfuscated_header_key_match_core.sv
sim/obfuscated_header_key_match_core_tb.sv
